FILE: rtl/spq_pkg.sv
// Package for the sorted priority queue: default sizes, fixed field widths
// and the control word shared by the top level and the queue cells.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

  // default configuration
  localparam int DEPTH_DEF     = 128;
  localparam int PRIO_BITS_DEF = 4;
  localparam int TAG_BITS_DEF  = 16;

  // occupancy field is a fixed-width report of the low count bits
  localparam int OCC_W = 8;

  // operation codes carried on in_cmd
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;   // insert the new word at its sorted place
    logic deq;   // shift everything one place toward the head
  } spq_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
// One queue cell: holds a single entry and trades it with its neighbors.
// Depends on spq_pkg for the control word type.
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; #(
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
) (
  input  logic                 clk,
  input  spq_ctrl_t            ctrl,
  input  logic                 occupied,    // this cell holds a live entry
  input  logic [PRIO_BITS-1:0] new_prio,
  input  logic [TAG_BITS-1:0]  new_tag,
  input  logic                 left_le,     // neighbor toward head keeps its entry
  input  logic [PRIO_BITS-1:0] left_prio,
  input  logic [TAG_BITS-1:0]  left_tag,
  input  logic [PRIO_BITS-1:0] right_prio,
  input  logic [TAG_BITS-1:0]  right_tag,
  output logic                 le,          // entry is served before the new word
  output logic [PRIO_BITS-1:0] prio,
  output logic [TAG_BITS-1:0]  tag
);

  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic [TAG_BITS-1:0]  tag_r, tag_nxt;

  // equal priority stays ahead, so ties leave in arrival order
  assign le = occupied && (prio_r <= new_prio);

  // keep, take the new word, take from the left, or shift in from the right
  always_comb begin
    prio_nxt = prio_r;
    tag_nxt  = tag_r;
    if (ctrl.enq && !le) begin
      if (left_le) begin
        prio_nxt = new_prio;
        tag_nxt  = new_tag;
      end else begin
        prio_nxt = left_prio;
        tag_nxt  = left_tag;
      end
    end else if (ctrl.deq) begin
      prio_nxt = right_prio;
      tag_nxt  = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

  assign prio = prio_r;
  assign tag  = tag_r;

endmodule

FILE: rtl/spq_outbuf.sv
// Result output register with a skid stage so a new word can be taken
// while the previous result waits. Depends on spq_pkg (style only).
`timescale 1ns / 1ps

module spq_outbuf import spq_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] out_data
);

  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  logic [W-1:0] out_data_r, out_data_nxt;
  logic [W-1:0] skid_data_r, skid_data_nxt;
  logic         take;

  assign take = out_valid_r && !out_stall;

  // refill output from skid first, park new word in skid when output holds
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/sorted_priority_queue_top.sv
// Sorted priority queue, built as a row of DEPTH cells that shift in parallel.
// Depends on spq_pkg, spq_cell and spq_outbuf.
//
// Use: each input word carries in_cmd (enqueue or dequeue), in_prio and in_tag.
// A word is accepted when in_valid is high and in_stall is low. Cell 0 holds
// the entry served next; an enqueue compares against every cell at once and
// the cells behind the insert point move one place back, a dequeue moves every
// cell one place toward the head. Equal priorities leave first in, first out.
// Every accepted word gives exactly one result word on the out_ channel,
// with the dequeued entry (if any), overflow/underflow flags and the
// occupancy, empty and full status after the operation.
// Throughput: one word per cycle while in_stall is low; the whole row updates
// in the accept cycle, and the result word is registered before it shows.
// Stall: the output register is backed by a one-word skid stage; in_stall
// rises only when both hold results, so at most two results wait.
// Reset (rst_n low, synchronous) empties the queue and drops pending results;
// no clearing pass is needed, cell contents are ignored past the count.
`timescale 1ns / 1ps

module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [PRIO_BITS-1:0] in_prio,
  input  logic [TAG_BITS-1:0]  in_tag,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_out_valid,
  output logic [PRIO_BITS-1:0] out_out_prio,
  output logic [TAG_BITS-1:0]  out_out_tag,
  output logic                 out_overflow,
  output logic                 out_underflow,
  output logic [OCC_W-1:0]     out_occupancy,
  output logic                 out_is_empty,
  output logic                 out_is_full
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RES_W = 1 + PRIO_BITS + TAG_BITS + 1 + 1 + OCC_W + 1 + 1;

  logic                 accept;
  logic                 full_now, empty_now;
  logic [CNT_W-1:0]     count_r, count_nxt;
  spq_ctrl_t            ctrl;

  logic                 cell_le   [DEPTH];
  logic                 cell_occ  [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio [DEPTH];
  logic [TAG_BITS-1:0]  cell_tag  [DEPTH];

  logic                 res_valid, res_ovf, res_udf;
  logic [PRIO_BITS-1:0] res_prio;
  logic [TAG_BITS-1:0]  res_tag;
  logic [OCC_W+CNT_W-1:0] occ_ext;
  logic [RES_W-1:0]     res_word, out_word;
  logic                 buf_full;

  assign accept    = in_valid && !in_stall;
  assign full_now  = (count_r == CNT_W'(DEPTH));
  assign empty_now = (count_r == '0);

  // command decode; refused operations leave the row untouched
  always_comb begin
    ctrl.enq = accept && (in_cmd == CMD_ENQ) && !full_now;
    ctrl.deq = accept && (in_cmd == CMD_DEQ) && !empty_now;
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (ctrl.enq) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.deq) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // row of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 l_le;
    logic [PRIO_BITS-1:0] l_prio, r_prio;
    logic [TAG_BITS-1:0]  l_tag, r_tag;

    assign cell_occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign l_le   = 1'b1;
      assign l_prio = in_prio;
      assign l_tag  = in_tag;
    end else begin : g_mid
      assign l_le   = cell_le[i-1];
      assign l_prio = cell_prio[i-1];
      assign l_tag  = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_prio = cell_prio[i];
      assign r_tag  = cell_tag[i];
    end else begin : g_body
      assign r_prio = cell_prio[i+1];
      assign r_tag  = cell_tag[i+1];
    end

    spq_cell #(
      .PRIO_BITS (PRIO_BITS),
      .TAG_BITS  (TAG_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (cell_occ[i]),
      .new_prio   (in_prio),
      .new_tag    (in_tag),
      .left_le    (l_le),
      .left_prio  (l_prio),
      .left_tag   (l_tag),
      .right_prio (r_prio),
      .right_tag  (r_tag),
      .le         (cell_le[i]),
      .prio       (cell_prio[i]),
      .tag        (cell_tag[i])
    );
  end

  // result word for this operation
  always_comb begin
    res_valid = ctrl.deq;
    res_prio  = ctrl.deq ? cell_prio[0] : '0;
    res_tag   = ctrl.deq ? cell_tag[0] : '0;
    res_ovf   = (in_cmd == CMD_ENQ) && full_now;
    res_udf   = (in_cmd == CMD_DEQ) && empty_now;
    occ_ext   = {{OCC_W{1'b0}}, count_nxt};
    res_word  = {res_valid, res_prio, res_tag, res_ovf, res_udf,
                 occ_ext[OCC_W-1:0],
                 (count_nxt == '0), (count_nxt == CNT_W'(DEPTH))};
  end

  spq_outbuf #(
    .W (RES_W)
  ) u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res_word),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_word)
  );

  assign in_stall = buf_full;

  assign {out_out_valid, out_out_prio, out_out_tag, out_overflow, out_underflow,
          out_occupancy, out_is_empty, out_is_full} = out_word;

endmodule

FILE: tb/sorted_priority_queue_top_test.sv
// Self-checking bench for sorted_priority_queue_top: a shadow copy of the sorted
// queue predicts each result word and a scoreboard class compares them in order.
// Depends on spq_pkg and the RTL of sorted_priority_queue_top.
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;
  import spq_pkg::*;

  localparam int DEPTH     = DEPTH_DEF;
  localparam int PRIO_BITS = PRIO_BITS_DEF;
  localparam int TAG_BITS  = TAG_BITS_DEF;
  localparam int LIMIT     = 200000;
  localparam int PHASE_LEN = 260;

  // one result word, fields in port order
  typedef struct packed {
    logic                 got;
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag;
    logic                 ovf;
    logic                 udf;
    logic [OCC_W-1:0]     occ;
    logic                 empty;
    logic                 full;
  } pq_word_t;

  // Shadow copy of the queue plus the list of result words still owed by the DUT
  class queue_mirror;
    localparam int CAP = DEPTH_DEF;

    // slots 0..held-1, largest priority number first, head in slot held-1
    logic [PRIO_BITS_DEF-1:0] slot_prio[CAP];
    logic [TAG_BITS_DEF-1:0]  slot_tag[CAP];
    int       held;
    int       errors;
    pq_word_t awaited[$];

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // apply one accepted operation to the shadow queue and queue up its result
    function void note_op(logic cmd, logic [PRIO_BITS_DEF-1:0] p,
                          logic [TAG_BITS_DEF-1:0] t);
      pq_word_t w;
      int       pos;
      w = '0;
      if (cmd == CMD_ENQ) begin
        if (held >= CAP) begin
          w.ovf = 1'b1;
        end else begin
          // everything served before the new entry moves one slot up
          pos = held;
          while (pos > 0 && slot_prio[pos-1] <= p) begin
            slot_prio[pos] = slot_prio[pos-1];
            slot_tag[pos]  = slot_tag[pos-1];
            pos--;
          end
          slot_prio[pos] = p;
          slot_tag[pos]  = t;
          held++;
        end
      end else begin
        if (held == 0) begin
          w.udf = 1'b1;
        end else begin
          held--;
          w.got  = 1'b1;
          w.prio = slot_prio[held];
          w.tag  = slot_tag[held];
        end
      end
      w.occ   = held[OCC_W-1:0];
      w.empty = (held == 0);
      w.full  = (held >= CAP);
      awaited.push_back(w);
    endfunction

    function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
      if (e != a) begin
        errors++;
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, e, a);
      end
    endfunction

    // compare one accepted result word with the oldest prediction
    function void check_word(pq_word_t a);
      pq_word_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result word, expected none, got 0x%0h", $time, a);
        return;
      end
      e = awaited.pop_front();
      cmp_field("out_valid", 32'(e.got), 32'(a.got));
      cmp_field("out_prio", 32'(e.prio), 32'(a.prio));
      cmp_field("out_tag", 32'(e.tag), 32'(a.tag));
      cmp_field("overflow", 32'(e.ovf), 32'(a.ovf));
      cmp_field("underflow", 32'(e.udf), 32'(a.udf));
      cmp_field("occupancy", 32'(e.occ), 32'(a.occ));
      cmp_field("is_empty", 32'(e.empty), 32'(a.empty));
      cmp_field("is_full", 32'(e.full), 32'(a.full));
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic                 in_cmd    = CMD_ENQ;
  logic [PRIO_BITS-1:0] in_prio   = '0;
  logic [TAG_BITS-1:0]  in_tag    = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_out_valid;
  logic [PRIO_BITS-1:0] out_out_prio;
  logic [TAG_BITS-1:0]  out_out_tag;
  logic                 out_overflow;
  logic                 out_underflow;
  logic [OCC_W-1:0]     out_occupancy;
  logic                 out_is_empty;
  logic                 out_is_full;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  int unsigned cycles    = 0;
  logic        filling   = 1'b1;
  queue_mirror mirror    = new();

  sorted_priority_queue_top #(
    .DEPTH(DEPTH), .PRIO_BITS(PRIO_BITS), .TAG_BITS(TAG_BITS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_prio(in_prio), .in_tag(in_tag),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_out_valid(out_out_valid), .out_out_prio(out_out_prio),
    .out_out_tag(out_out_tag), .out_overflow(out_overflow),
    .out_underflow(out_underflow), .out_occupancy(out_occupancy),
    .out_is_empty(out_is_empty), .out_is_full(out_is_full)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // result monitor
  always @(posedge clk) begin : watch_results
    pq_word_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.got   = out_out_valid;
      seen.prio  = out_out_prio;
      seen.tag   = out_out_tag;
      seen.ovf   = out_overflow;
      seen.udf   = out_underflow;
      seen.occ   = out_occupancy;
      seen.empty = out_is_empty;
      seen.full  = out_is_full;
      mirror.check_word(seen);
    end
  end

  // present one word, with random idle cycles ahead of it, and wait for accept
  task automatic send_word(input logic cmd, input logic [PRIO_BITS-1:0] p,
                           input logic [TAG_BITS-1:0] t);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_prio  <= p;
    in_tag   <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mirror.note_op(cmd, p, t);
  endtask

  // drop valid and hold off until every owed result word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.awaited.size() != 0) @(posedge clk);
  endtask

  // random traffic that climbs to full, lingers, then sinks to empty, and so on
  task automatic run_mix(input int n);
    logic                 cmd;
    logic [PRIO_BITS-1:0] p;
    logic [TAG_BITS-1:0]  t;
    int                   enq_pct;
    for (int i = 0; i < n; i++) begin
      if (mirror.held == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (mirror.held == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      enq_pct = filling ? 80 : 20;
      cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      p   = PRIO_BITS'($urandom_range(0, (1 << PRIO_BITS) - 1));
      t   = TAG_BITS'($urandom_range(0, (1 << TAG_BITS) - 1));
      send_word(cmd, p, t);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: underflow, extremes, ties at head, middle and tail, full drain
    send_word(CMD_DEQ, '1, '1);
    send_word(CMD_ENQ, 4'd15, 16'hFFFF);
    send_word(CMD_ENQ, 4'd0, 16'h0000);
    send_word(CMD_ENQ, 4'd7, 16'hA5A5);
    send_word(CMD_ENQ, 4'd7, 16'h5A5A);
    send_word(CMD_ENQ, 4'd7, 16'h1234);
    send_word(CMD_ENQ, 4'd0, 16'h0001);
    send_word(CMD_ENQ, 4'd15, 16'hFFFE);
    repeat (7) send_word(CMD_DEQ, 4'd0, 16'h0000);
    send_word(CMD_DEQ, 4'd15, 16'hFFFF);
    drain_results();

    // random phases: no idling, sender gaps, receiver stalls, both
    idle_pct = 0;  stall_pct = 0;
    run_mix(PHASE_LEN);
    drain_results();
    idle_pct = 65; stall_pct = 0;
    run_mix(PHASE_LEN);
    drain_results();
    idle_pct = 0;  stall_pct = 65;
    run_mix(PHASE_LEN);
    drain_results();
    idle_pct = 16; stall_pct = 16;
    run_mix(PHASE_LEN);

    // wrap-up: let owed words arrive, then a few quiet cycles for stragglers
    drain_results();
    repeat (10) @(posedge clk);
    if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
